// ===== rtl/core/ihg_pkg.sv =====
`default_nettype none

package ihg_pkg;

    localparam int unsigned HdrWords   = 5;
    localparam int unsigned HdrBytes   = 20;
    localparam int unsigned HdrVersion = 4;
    localparam int unsigned HdrIhl     = 5;
    localparam int unsigned HdrTtl     = 64;
    localparam int unsigned HdrDfBit   = 14;

    typedef logic [2:0] word_idx_t;

    localparam word_idx_t WORD_FIRST = 3'd0;
    localparam word_idx_t WORD_FLAGS = 3'd1;
    localparam word_idx_t WORD_CSUM  = 3'd2;
    localparam word_idx_t WORD_SRC   = 3'd3;
    localparam word_idx_t WORD_LAST  = 3'd4;

    // upper half of header word 0: version and ihl, dscp/ecn zero
    localparam logic [15:0] VER_IHL_HALF = 16'((HdrVersion << 12) | (HdrIhl << 8));
    localparam logic [15:0] FLAGS_HALF   = 16'(1 << HdrDfBit);
    localparam logic [7:0]  TTL_BYTE     = 8'(HdrTtl);
    localparam logic [16:0] HDR_LEN      = 17'(HdrBytes);

endpackage

`default_nettype wire

// ===== rtl/core/ipv4_header_generator.sv =====
`default_nettype none

// IPv4 header generator. A request is taken at a clock edge with start high
// and busy low; the 20-byte header then comes out of the output register as
// five consecutive 32-bit beats on header_word, each marked by strobe for one
// cycle, last_word on the fifth, length_overflow on all five. The receiver
// cannot stall: every beat must be taken in the cycle it is shown. The output
// register carries one beat per cycle; busy drops while the fifth beat is being
// loaded, so a request may follow in that cycle and its beats continue without
// a gap. The checksum is summed and folded from the request registers while the
// first two beats are loaded. local_address is written with config_write and
// config_data; the user must do so only while idle, the block does not check.
module ipv4_header_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        config_write,
    input  wire logic [31:0] config_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] remote_address,
    input  wire logic [7:0]  protocol,
    input  wire logic [15:0] payload_length,
    output logic             strobe,
    output logic [31:0]      header_word,
    output logic             last_word,
    output logic             length_overflow
);
    import ihg_pkg::*;

    logic [31:0] local_address_reg;

    logic        active_reg;
    word_idx_t   idx_reg;

    logic [31:0] remote_reg;
    logic [7:0]  protocol_reg;
    logic [15:0] total_len_reg;
    logic        overflow_reg;

    logic [18:0] sum_reg;
    logic [15:0] csum_reg;

    logic        strobe_reg;
    logic [31:0] header_word_reg;
    logic        last_word_reg;
    logic        overflow_out_reg;

    logic        accept;
    logic [16:0] full_len;
    logic [18:0] sum_next;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [31:0] word_sel;

    assign busy     = active_reg && (idx_reg != WORD_LAST);
    assign accept   = start && !busy;
    assign full_len = {1'b0, payload_length} + HDR_LEN;

    // ones-complement sum of the header halves with checksum field zero
    always_comb
    begin
        sum_next = 19'(VER_IHL_HALF) + 19'(total_len_reg) + 19'(FLAGS_HALF)
                 + 19'({TTL_BYTE, protocol_reg})
                 + 19'(local_address_reg[31:16]) + 19'(local_address_reg[15:0])
                 + 19'(remote_reg[31:16]) + 19'(remote_reg[15:0]);
        fold1    = 17'(sum_reg[15:0]) + 17'(sum_reg[18:16]);
        fold2    = fold1[15:0] + 16'(fold1[16]);
    end

    always_comb
    begin
        case (idx_reg)
            WORD_FIRST: word_sel = {VER_IHL_HALF, total_len_reg};
            WORD_FLAGS: word_sel = {16'h0000, FLAGS_HALF};
            WORD_CSUM:  word_sel = {TTL_BYTE, protocol_reg, csum_reg};
            WORD_SRC:   word_sel = local_address_reg;
            WORD_LAST:  word_sel = remote_reg;
            default:    word_sel = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= 32'h0000_0000;
            active_reg        <= 1'b0;
            idx_reg           <= WORD_FIRST;
            strobe_reg        <= 1'b0;
        end
        else
        begin
            if (config_write)
            begin
                local_address_reg <= config_data;
            end
            if (accept)
            begin
                active_reg <= 1'b1;
                idx_reg    <= WORD_FIRST;
            end
            else if (active_reg)
            begin
                if (idx_reg == WORD_LAST)
                begin
                    active_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 3'd1;
            end
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            remote_reg    <= remote_address;
            protocol_reg  <= protocol;
            total_len_reg <= full_len[15:0];
            overflow_reg  <= full_len[16];
        end
        if (active_reg && idx_reg == WORD_FIRST)
        begin
            sum_reg <= sum_next;
        end
        if (active_reg && idx_reg == WORD_FLAGS)
        begin
            csum_reg <= ~fold2;
        end
        if (active_reg)
        begin
            header_word_reg  <= word_sel;
            last_word_reg    <= (idx_reg == WORD_LAST);
            overflow_out_reg <= overflow_reg;
        end
    end

    assign strobe          = strobe_reg;
    assign header_word     = header_word_reg;
    assign last_word       = strobe_reg && last_word_reg;
    assign length_overflow = overflow_out_reg;

    // a request yields a first beat that is not last, and later its last beat
    a_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 (strobe && !last_word))
        else $error("first header beat not seen two cycles after request");

    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 (strobe && last_word))
        else $error("last header beat not seen six cycles after request");

    // beats of one header come without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_word) |=> strobe)
        else $error("gap inside a header");

    a_busy_active: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> active_reg && (idx_reg != WORD_LAST))
        else $error("busy without a request in flight");

    a_csum_word: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && idx_reg == WORD_CSUM) |=> (header_word[31:24] == TTL_BYTE))
        else $error("third beat lacks ttl");

endmodule

`default_nettype wire

// ===== dv/ipv4_header_generator_tb.sv =====
`timescale 1ns / 100ps

module ipv4_header_generator_tb;

    import ihg_pkg::*;

    localparam int CYCLE_LIMIT   = 60000;
    localparam int DRAIN_SETTLE  = 4;
    localparam int TAIL_CYCLES   = 12;
    localparam int DIRECTED_ROWS = 16;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 40;

    typedef struct packed {
        logic [HdrWords-1:0][31:0] words;
        logic                      ovf;
    } ipv4_header_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        ovf;
    } header_beat_t;

    // one request; len/csum/ovf are hand-typed expectations used where flagged
    typedef struct packed {
        logic        set_src;
        logic [31:0] src_val;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] plen;
        logic        has_len;
        logic [15:0] len;
        logic        ovf;
        logic        has_csum;
        logic [15:0] csum;
    } request_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        config_write;
    logic [31:0] config_data;
    logic        start;
    logic        busy;
    logic [31:0] remote_address;
    logic [7:0]  protocol;
    logic [15:0] payload_length;
    logic        strobe;
    logic [31:0] header_word;
    logic        last_word;
    logic        length_overflow;

    header_beat_t pending_beats[$];
    request_row_t directed_rows[DIRECTED_ROWS];
    logic [31:0]  src_address;
    int           bad_beats = 0;
    int           cycles = 0;

    ipv4_header_generator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .config_write    (config_write),
        .config_data     (config_data),
        .start           (start),
        .busy            (busy),
        .remote_address  (remote_address),
        .protocol        (protocol),
        .payload_length  (payload_length),
        .strobe          (strobe),
        .header_word     (header_word),
        .last_word       (last_word),
        .length_overflow (length_overflow)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, pending_beats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic ipv4_header_t ipv4_header(input logic [31:0] src, input logic [31:0] dst,
                                                 input logic [7:0] proto,
                                                 input logic [15:0] plen);
        ipv4_header_t hdr;
        logic [16:0]  full_len;
        logic [31:0]  sum;
        full_len = HDR_LEN + {1'b0, plen};
        hdr.ovf = full_len[16];
        hdr.words[WORD_FIRST] = {VER_IHL_HALF, full_len[15:0]};
        hdr.words[WORD_FLAGS] = {16'h0000, FLAGS_HALF};
        hdr.words[WORD_CSUM]  = {TTL_BYTE, proto, 16'h0000};
        hdr.words[WORD_SRC]   = src;
        hdr.words[WORD_LAST]  = dst;
        sum = 32'd0;
        for (int k = 0; k < HdrWords; k++)
            sum = sum + hdr.words[k][31:16] + hdr.words[k][15:0];
        // end-around carry until it settles
        while (sum[31:16] != 16'd0)
            sum = sum[15:0] + sum[31:16];
        hdr.words[WORD_CSUM][15:0] = ~sum[15:0];
        return hdr;
    endfunction

    task automatic send_request(input request_row_t row);
        ipv4_header_t hdr;
        header_beat_t beat;
        start          <= 1'b1;
        remote_address <= row.dst;
        protocol       <= row.proto;
        payload_length <= row.plen;
        do
            @(posedge clk);
        while (busy);
        hdr = ipv4_header(src_address, row.dst, row.proto, row.plen);
        for (int k = 0; k < HdrWords; k++)
        begin
            beat.word = hdr.words[k];
            beat.last = (word_idx_t'(k) == WORD_LAST);
            beat.ovf  = row.has_len ? row.ovf : hdr.ovf;
            if (row.has_len && word_idx_t'(k) == WORD_FIRST)
                beat.word = {VER_IHL_HALF, row.len};
            if (row.has_csum && word_idx_t'(k) == WORD_CSUM)
                beat.word = {TTL_BYTE, row.proto, row.csum};
            pending_beats.push_back(beat);
        end
        @(negedge clk);
    endtask

    task automatic idle_for(input int n);
        start          <= 1'b0;
        remote_address <= $urandom;
        protocol       <= 8'($urandom);
        payload_length <= 16'($urandom);
        repeat (n) @(negedge clk);
    endtask

    // hold off until every header has drained, then load a new source address
    task automatic drain_and_write(input logic [31:0] value);
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SETTLE) @(negedge clk);
        config_write <= 1'b1;
        config_data  <= value;
        @(posedge clk);
        src_address = value;
        @(negedge clk);
        config_write <= 1'b0;
        config_data  <= $urandom;
    endtask

    always @(posedge clk)
    begin
        header_beat_t want;
        if (rst_n && strobe)
        begin
            if (pending_beats.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected beat: word %h last %b ovf %b",
                             header_word, last_word, length_overflow);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (header_word !== want.word || last_word !== want.last
                    || length_overflow !== want.ovf)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display({"beat mismatch: expected word %h last %b ovf %b,",
                                  " got word %h last %b ovf %b"},
                                 want.word, want.last, want.ovf,
                                 header_word, last_word, length_overflow);
                end
            end
        end
    end

    initial
    begin
        request_row_t row;
        logic [31:0]  phase_src;
        // set_src src_val dst proto plen | has_len len ovf | has_csum csum
        directed_rows = '{
            '{1'b0, 32'h0, 32'h0000_0000, 8'h00, 16'h0000, 1'b1, 16'h0014, 1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1, 16'h0013, 1'b1, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h0102_0304, 8'h06, 16'hFFEB, 1'b1, 16'hFFFF, 1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h0A0B_0C0D, 8'h11, 16'hFFEC, 1'b1, 16'h0000, 1'b1, 1'b0, 16'h0},
            // folded sum of all ones gives a zero checksum
            '{1'b0, 32'h0, 32'h3AEB_0000, 8'h00, 16'h0000, 1'b1, 16'h0014, 1'b0, 1'b1, 16'h0000},
            '{1'b0, 32'h0, 32'hC0A8_0001, 8'h06, 16'd100,  1'b1, 16'h0078, 1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h0A00_0001, 8'h11, 16'd8,    1'b1, 16'h001C, 1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h7F00_0001, 8'h01, 16'hAAAA, 1'b1, 16'hAABE, 1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h5555_5555, 8'h55, 16'h5555, 1'b0, 16'h0,    1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'hAAAA_AAAA, 8'hAA, 16'h8000, 1'b1, 16'h8014, 1'b0, 1'b0, 16'h0},
            '{1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 16'h0000,
              1'b1, 16'h0014, 1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h3AEB_0000, 8'h00, 16'h0000, 1'b1, 16'h0014, 1'b0, 1'b1, 16'h0000},
            '{1'b0, 32'h0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1, 16'h0013, 1'b1, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h0102_0304, 8'h06, 16'd1460, 1'b0, 16'h0,    1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'h8000_0001, 8'h80, 16'h0001, 1'b1, 16'h0015, 1'b0, 1'b0, 16'h0},
            '{1'b0, 32'h0, 32'hDEAD_BEEF, 8'h11, 16'h1234, 1'b0, 16'h0,    1'b0, 1'b0, 16'h0}
        };

        rst_n          = 1'b0;
        config_write   = 1'b0;
        config_data    = 32'd0;
        start          = 1'b0;
        remote_address = 32'd0;
        protocol       = 8'd0;
        payload_length = 16'd0;
        src_address    = 32'd0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // back to back save the source-write drain; source at reset value first
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].set_src)
                drain_and_write(directed_rows[i].src_val);
            send_request(directed_rows[i]);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1: phase_src = 32'h0000_0000;
                3: phase_src = 32'hFFFF_FFFF;
                default: phase_src = $urandom;
            endcase
            drain_and_write(phase_src);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                row = '0;
                row.dst   = $urandom;
                row.proto = 8'($urandom);
                row.plen  = 16'($urandom);
                case ($urandom_range(0, 7))
                    0: row.dst = 32'h0000_0000;
                    1: row.dst = 32'hFFFF_FFFF;
                    default: ;
                endcase
                // lean on the wrap boundary and on short segments
                case ($urandom_range(0, 7))
                    0, 1: row.plen = 16'($urandom_range(65500, 65535));
                    2: row.plen = 16'($urandom_range(65513, 65518));
                    3: row.plen = 16'($urandom_range(0, 40));
                    default: ;
                endcase
                send_request(row);
                // no idling in the final phase
                if (phase < RANDOM_PHASES - 1 && $urandom_range(0, 2) == 0)
                    idle_for($urandom_range(1, 9));
            end
        end

        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (bad_beats == 0 && pending_beats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
